/* design/pst_pkg.sv */
// ----------------------------------------------------------------------------
// pst_pkg
// types and codes shared by the peer statistics table modules
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

  localparam logic [1:0] ADDR_AGE_LIMIT = 2'd0;

  typedef enum logic [1:0] {
    OP_RX   = 2'd0,
    OP_TX   = 2'd1,
    OP_AGE  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_MODIFY,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] rx_time;
    logic [31:0] tx_time;
    logic [31:0] rx_cnt;
    logic [31:0] pfail_cnt;
    logic [31:0] tx_cnt;
    logic [31:0] txfail_cnt;
  } entry_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] ip;
    logic [15:0] port;
    logic        failed;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic        inserted;
    logic        table_full;
    logic [3:0]  slot;
    logic [31:0] rx_total;
    logic [31:0] tx_total;
    logic [31:0] fail_total;
    logic [4:0]  removed_count;
  } res_t;

endpackage

`default_nettype wire

/* design/pst_mem.sv */
// ----------------------------------------------------------------------------
// pst_mem
// simple dual port entry memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pst_mem
  import pst_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* design/pst_engine.sv */
// ----------------------------------------------------------------------------
// pst_engine
// scan sequencer: walks entry memory once per item; rx/tx may update one entry
// ----------------------------------------------------------------------------
`default_nettype none

module pst_engine
  import pst_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire req_t        req,
  input  wire logic [31:0] age_limit,
  output logic             idle,
  output logic             res_valid,
  output res_t             res,
  input  wire logic        res_ready
);

  localparam int IDXW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNTW = $clog2(TABLE_ENTRIES + 1);

  state_t                    state_r, state_nxt;
  req_t                      req_r, req_nxt;
  logic [CNTW-1:0]           cnt_r, cnt_nxt;
  logic                      chk_vld_r, chk_vld_nxt;
  logic [IDXW-1:0]           chk_idx_r, chk_idx_nxt;
  logic                      found_r, found_nxt;
  logic [IDXW-1:0]           match_r, match_nxt;
  logic                      freev_r, freev_nxt;
  logic [IDXW-1:0]           free_r, free_nxt;
  logic [CNTW-1:0]           removed_r, removed_nxt;
  logic [TABLE_ENTRIES-1:0]  valid_r, valid_nxt;
  res_t                      res_r, res_nxt;

  logic                      rd_en, wr_en;
  logic [IDXW-1:0]           rd_addr, wr_addr;
  entry_t                    rd_data, wr_data;

  logic                      issue, ent_v, key_hit, expire, found_c, freev_c;
  logic [IDXW-1:0]           match_c, free_c;
  logic [CNTW-1:0]           removed_c;
  logic [31:0]               age;
  logic [IDXW+3:0]           match_ext, free_ext;
  logic [CNTW+4:0]           rem_ext;

  pst_mem #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (IDXW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign issue   = (cnt_r != CNTW'(TABLE_ENTRIES));
  assign ent_v   = chk_vld_r && valid_r[chk_idx_r];
  assign key_hit = ent_v && (rd_data.ip == req_r.ip) && (rd_data.port == req_r.port);
  assign age     = req_r.now_ms - rd_data.rx_time;
  assign expire  = ent_v && (age > age_limit);

  assign found_c   = found_r || key_hit;
  assign match_c   = found_r ? match_r : chk_idx_r;
  assign freev_c   = freev_r || (chk_vld_r && !valid_r[chk_idx_r]);
  assign free_c    = freev_r ? free_r : chk_idx_r;
  assign removed_c = removed_r + CNTW'(expire);

  assign match_ext = {4'b0, match_r};
  assign free_ext  = {4'b0, free_c};
  assign rem_ext   = {5'b0, removed_c};

  assign idle      = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res       = res_r;

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    cnt_nxt     = cnt_r;
    chk_vld_nxt = 1'b0;
    chk_idx_nxt = chk_idx_r;
    found_nxt   = found_r;
    match_nxt   = match_r;
    freev_nxt   = freev_r;
    free_nxt    = free_r;
    removed_nxt = removed_r;
    valid_nxt   = valid_r;
    res_nxt     = res_r;
    rd_en       = 1'b0;
    rd_addr     = match_r;
    wr_en       = 1'b0;
    wr_addr     = match_r;
    wr_data     = rd_data;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt     = req;
          cnt_nxt     = '0;
          found_nxt   = 1'b0;
          freev_nxt   = 1'b0;
          removed_nxt = '0;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rd_en       = 1'b1;
          rd_addr     = cnt_r[IDXW-1:0];
          cnt_nxt     = cnt_r + 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = cnt_r[IDXW-1:0];
        end
        found_nxt = found_c;
        match_nxt = match_c;
        freev_nxt = freev_c;
        free_nxt  = free_c;
        if (req_r.op == OP_AGE) begin
          removed_nxt = removed_c;
          if (expire) begin
            valid_nxt[chk_idx_r] = 1'b0;
          end
        end
        if (chk_vld_r && !issue) begin
          res_nxt   = '0;
          state_nxt = ST_DONE;
          case (req_r.op)
            OP_AGE: begin
              res_nxt.removed_count = rem_ext[4:0];
            end
            OP_RX: begin
              if (found_c) begin
                state_nxt = ST_READ;
              end else if (freev_c) begin
                wr_en              = 1'b1;
                wr_addr            = free_c;
                wr_data            = '0;
                wr_data.ip         = req_r.ip;
                wr_data.port       = req_r.port;
                wr_data.rx_time    = req_r.now_ms;
                wr_data.rx_cnt     = 32'd1;
                wr_data.pfail_cnt  = {31'd0, req_r.failed};
                valid_nxt[free_c]  = 1'b1;
                res_nxt.inserted   = 1'b1;
                res_nxt.slot       = free_ext[3:0];
                res_nxt.rx_total   = 32'd1;
                res_nxt.fail_total = {31'd0, req_r.failed};
              end else begin
                res_nxt.table_full = 1'b1;
              end
            end
            OP_TX: begin
              if (found_c) begin
                state_nxt = ST_READ;
              end
            end
            default: begin
              res_nxt = '0;
            end
          endcase
        end
      end
      ST_READ: begin
        rd_en     = 1'b1;
        rd_addr   = match_r;
        state_nxt = ST_MODIFY;
      end
      ST_MODIFY: begin
        wr_en          = 1'b1;
        wr_addr        = match_r;
        wr_data        = rd_data;
        res_nxt        = '0;
        res_nxt.hit    = 1'b1;
        res_nxt.slot   = match_ext[3:0];
        if (req_r.op == OP_TX) begin
          wr_data.tx_time    = req_r.now_ms;
          wr_data.tx_cnt     = rd_data.tx_cnt + 32'd1;
          wr_data.txfail_cnt = rd_data.txfail_cnt + {31'd0, req_r.failed};
          res_nxt.fail_total = wr_data.txfail_cnt;
        end else begin
          wr_data.rx_time    = req_r.now_ms;
          wr_data.rx_cnt     = rd_data.rx_cnt + 32'd1;
          wr_data.pfail_cnt  = rd_data.pfail_cnt + {31'd0, req_r.failed};
          res_nxt.fail_total = wr_data.pfail_cnt;
        end
        res_nxt.rx_total = wr_data.rx_cnt;
        res_nxt.tx_total = wr_data.tx_cnt;
        state_nxt        = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      chk_vld_r <= 1'b0;
      found_r   <= 1'b0;
      freev_r   <= 1'b0;
      removed_r <= '0;
      valid_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      chk_vld_r <= chk_vld_nxt;
      found_r   <= found_nxt;
      freev_r   <= freev_nxt;
      removed_r <= removed_nxt;
      valid_r   <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    chk_idx_r <= chk_idx_nxt;
    match_r   <= match_nxt;
    free_r    <= free_nxt;
    res_r     <= res_nxt;
  end

endmodule

`default_nettype wire

/* design/udp_peer_stats_table.sv */
// ----------------------------------------------------------------------------
// udp_peer_stats_table
// peer table keyed by ip and port, with rx/tx counters and an age sweep
// ----------------------------------------------------------------------------
// flow: each item scans all entries, one entry per cycle through the single
//   memory read port; an rx/tx hit adds a read and a modify step before the
//   result; a new item is accepted only while the engine is idle
// reset: synchronous active low; clears all entry valid bits, age_limit to 60000
// ----------------------------------------------------------------------------
`default_nettype none

module udp_peer_stats_table
  import pst_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [87:0]  in_tdata,   // peer_ip, peer_port, failed, now_ms, zero pad
  input  wire logic [1:0]   in_tuser,   // operation
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [111:0]      out_tdata,  // slot, rx_total, tx_total, fail_total,
                                        // removed_count, zero pad
  output logic [2:0]        out_tuser,  // hit, inserted, table_full
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [1:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [31:0] age_limit_r;
  logic        eng_idle, res_valid, res_ready, start;
  req_t        req;
  res_t        res, out_r;
  logic        out_valid_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_AGE_LIMIT) ? age_limit_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_limit_r <= 32'd60000;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      age_limit_r <= cfg_pwdata;
    end
  end

  assign in_tready  = eng_idle;
  assign start      = in_tvalid && in_tready;
  assign req.op     = op_t'(in_tuser);
  assign req.ip     = in_tdata[31:0];
  assign req.port   = in_tdata[47:32];
  assign req.failed = in_tdata[48];
  assign req.now_ms = in_tdata[80:49];

  pst_engine #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (req),
    .age_limit (age_limit_r),
    .idle      (eng_idle),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_r.table_full, out_r.inserted, out_r.hit};
  assign out_tdata  = {7'd0, out_r.removed_count, out_r.fail_total, out_r.tx_total,
                       out_r.rx_total, out_r.slot};

`ifndef SYNTHESIS
  a_flags_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tuser))
    else $error("more than one result flag set");

  a_insert_first_rx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata[35:4] == 32'd1 && out_tdata[67:36] == 32'd0)
    else $error("new entry with wrong counters");

  a_sweep_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[104:100] != 5'd0 |-> out_tuser == 3'd0)
    else $error("age sweep result carries lookup flags");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> !in_tready)
    else $error("item accepted while a result is pending in the engine");
`endif

endmodule

`default_nettype wire
